FILE: rtl/divide_64bit_signed_unsigned_top_defines.svh
// Assertion macros for the pipelined restoring divider.
// Used by divide_64bit_signed_unsigned_top; needs clk and rst_n in scope.
`ifndef DIVIDE_64BIT_SIGNED_UNSIGNED_TOP_DEFINES_SVH
`define DIVIDE_64BIT_SIGNED_UNSIGNED_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during reset
`define D64_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("divider assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define D64_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("divider assertion failed");

`else

`define D64_ASSERT_IMP(lbl, ante, cons)
`define D64_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/div64_pkg.sv
// Package for the pipelined restoring divider: widths, command codes,
// item and pipeline stage types. No dependencies.
`timescale 1ns / 1ps

package div64_pkg;

    // working width of the division, 8 to 64
    localparam int unsigned DATA_WIDTH = 64;
    // width of the item fields on the ports
    localparam int unsigned IO_WIDTH   = 64;

    // command codes
    localparam logic CMD_UNSIGNED = 1'b0;
    localparam logic CMD_SIGNED   = 1'b1;

    // input item
    typedef struct packed {
        logic [IO_WIDTH-1:0] dividend;
        logic [IO_WIDTH-1:0] divisor;
        logic                command;
    } op_t;

    // result item
    typedef struct packed {
        logic [IO_WIDTH-1:0] quotient;
        logic [IO_WIDTH-1:0] remainder;
        logic                divide_by_zero;
    } res_t;

    // state handed from cell to cell
    typedef struct packed {
        logic [DATA_WIDTH-1:0] rem;    // partial remainder
        logic [DATA_WIDTH-1:0] quo;    // dividend bits shifting out, quotient bits in
        logic [DATA_WIDTH-1:0] den;    // divisor magnitude
        logic                  neg_q;  // negate quotient at the end
        logic                  neg_r;  // negate remainder at the end
        logic                  dz;     // divisor was zero
    } stage_t;

endpackage

FILE: rtl/div64_prep.sv
// Input stage of the divider: takes magnitudes in signed mode, flags a
// zero divisor and loads the first cell state. Depends on div64_pkg.
`timescale 1ns / 1ps

module div64_prep (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_stall,
    input  div64_pkg::op_t    up,
    output logic              dn_valid,
    input  logic              dn_stall,
    output div64_pkg::stage_t dn
);
    import div64_pkg::*;

    logic [DATA_WIDTH-1:0] num;
    logic [DATA_WIDTH-1:0] den;
    logic                  signed_mode;
    logic                  num_neg;
    logic                  den_neg;
    stage_t                prep_next;
    logic                  valid_reg;
    stage_t                data_reg;

    // operand magnitudes and sign fixups
    always_comb
    begin
        num         = up.dividend[DATA_WIDTH-1:0];
        den         = up.divisor[DATA_WIDTH-1:0];
        signed_mode = (up.command == CMD_SIGNED);
        num_neg     = signed_mode && num[DATA_WIDTH-1];
        den_neg     = signed_mode && den[DATA_WIDTH-1];
        prep_next.rem   = '0;
        prep_next.quo   = num_neg ? (~num + 1'b1) : num;
        prep_next.den   = den_neg ? (~den + 1'b1) : den;
        prep_next.neg_q = num_neg ^ den_neg;
        prep_next.neg_r = num_neg;
        prep_next.dz    = (den == '0);
    end

    // stage holds while its item waits downstream
    assign up_stall = valid_reg && dn_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            data_reg <= prep_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn       = data_reg;

endmodule

FILE: rtl/div64_cell.sv
// One restoring division step with its pipeline register; a row of these
// makes the divider. Depends on div64_pkg.
`timescale 1ns / 1ps

module div64_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_stall,
    input  div64_pkg::stage_t up,
    output logic              dn_valid,
    input  logic              dn_stall,
    output div64_pkg::stage_t dn
);
    import div64_pkg::*;

    logic                  carry;
    logic [DATA_WIDTH-1:0] shifted;
    logic [DATA_WIDTH:0]   diff;
    logic                  ge;
    stage_t                step;
    logic                  valid_reg;
    stage_t                data_reg;

    // shift in next dividend bit, trial subtract, keep or restore
    always_comb
    begin
        carry     = up.rem[DATA_WIDTH-1];
        shifted   = {up.rem[DATA_WIDTH-2:0], up.quo[DATA_WIDTH-1]};
        diff      = {carry, shifted} - {1'b0, up.den};
        ge        = ~diff[DATA_WIDTH];
        step      = up;
        step.rem  = ge ? diff[DATA_WIDTH-1:0] : shifted;
        step.quo  = {up.quo[DATA_WIDTH-2:0], ge};
    end

    // stage holds while its item waits downstream
    assign up_stall = valid_reg && dn_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            data_reg <= step;
        end
    end

    assign dn_valid = valid_reg;
    assign dn       = data_reg;

endmodule

FILE: rtl/div64_post.sv
// Output stage of the divider: restores result signs, forces zeros on a
// zero divisor and holds the result item. Depends on div64_pkg.
`timescale 1ns / 1ps

module div64_post (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_stall,
    input  div64_pkg::stage_t up,
    output logic              dn_valid,
    input  logic              dn_stall,
    output div64_pkg::res_t   dn
);
    import div64_pkg::*;

    logic [DATA_WIDTH-1:0] quo_fix;
    logic [DATA_WIDTH-1:0] rem_fix;
    res_t                  res_next;
    logic                  valid_reg;
    res_t                  data_reg;

    // sign correction and zero divisor override
    always_comb
    begin
        quo_fix = up.neg_q ? (~up.quo + 1'b1) : up.quo;
        rem_fix = up.neg_r ? (~up.rem + 1'b1) : up.rem;
        res_next.quotient       = up.dz ? '0 : IO_WIDTH'(quo_fix);
        res_next.remainder      = up.dz ? '0 : IO_WIDTH'(rem_fix);
        res_next.divide_by_zero = up.dz;
    end

    // result register holds while the item is stalled
    assign up_stall = valid_reg && dn_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            data_reg <= res_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn       = data_reg;

endmodule

FILE: rtl/divide_64bit_signed_unsigned_top.sv
// Pipeline: one input stage, one restoring cell per quotient bit and one
// output stage, each with its own register.
// Throughput: one item per cycle while res_stall is low; each cell holds one
// item; a stalled result only stops full stages, so empty stages keep filling.
// Reset: rst_n clears all stage valid bits asynchronously; no other state.
`timescale 1ns / 1ps
`include "divide_64bit_signed_unsigned_top_defines.svh"

module divide_64bit_signed_unsigned_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    output logic              op_stall,
    input  div64_pkg::op_t    op,
    output logic              res_valid,
    input  logic              res_stall,
    output div64_pkg::res_t   res
);
    import div64_pkg::*;

    logic   link_valid [DATA_WIDTH+1];
    logic   link_stall [DATA_WIDTH+1];
    stage_t link_data  [DATA_WIDTH+1];

    // operand conditioning
    div64_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (op_valid),
        .up_stall (op_stall),
        .up       (op),
        .dn_valid (link_valid[0]),
        .dn_stall (link_stall[0]),
        .dn       (link_data[0])
    );

    // one cell per quotient bit, most significant first
    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_cell
        div64_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (link_valid[i]),
            .up_stall (link_stall[i]),
            .up       (link_data[i]),
            .dn_valid (link_valid[i+1]),
            .dn_stall (link_stall[i+1]),
            .dn       (link_data[i+1])
        );
    end

    // sign restore and result register
    div64_post u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (link_valid[DATA_WIDTH]),
        .up_stall (link_stall[DATA_WIDTH]),
        .up       (link_data[DATA_WIDTH]),
        .dn_valid (res_valid),
        .dn_stall (res_stall),
        .dn       (res)
    );

    // zero divisor gives all-zero results
    `D64_ASSERT_IMP(a_dz_zero, res_valid && res.divide_by_zero, (res.quotient == '0) && (res.remainder == '0))
    // final partial remainder is below the divisor magnitude
    `D64_ASSERT_IMP(a_rem_bound, link_valid[DATA_WIDTH] && !link_data[DATA_WIDTH].dz, link_data[DATA_WIDTH].rem < link_data[DATA_WIDTH].den)
    // an item in the last cell with a free output stage moves to the output
    `D64_ASSERT_NXT(a_last_moves, link_valid[DATA_WIDTH] && !link_stall[DATA_WIDTH], res_valid)

endmodule
